// File: rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg: shared types and constants of the complex pointwise divider
// Word layouts for both channels and the data carried along the divider chain.
// ----------------------------------------------------------------------------
package cpd_pkg;

  // Largest number of pairs that may be active.
  localparam int unsigned MAX_PAIRS = 4096;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned NUM_W = PROD_W + FRAC_W;
  // One divider cell per quotient bit.
  localparam int unsigned NUM_CELLS = NUM_W;

  typedef struct packed {
    logic [IDX_W-1:0]         pair_index;
    logic signed [DATA_W-1:0] numerator_real;
    logic signed [DATA_W-1:0] numerator_imag;
    logic signed [DATA_W-1:0] denominator_real;
    logic signed [DATA_W-1:0] denominator_imag;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quotient_real;
    logic signed [DATA_W-1:0] quotient_imag;
    logic                     written;
    logic                     divide_by_zero;
    logic                     saturated;
  } out_word_t;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic              active;
    logic              zero;
    logic [PROD_W-1:0] den;
    logic              neg_re;
    logic              neg_im;
    logic [NUM_W-1:0]  num_re;
    logic [NUM_W-1:0]  num_im;
    logic [PROD_W-1:0] rem_re;
    logic [PROD_W-1:0] rem_im;
    logic [DATA_W-1:0] q_re;
    logic [DATA_W-1:0] q_im;
    logic              big_re;
    logic              big_im;
  } cell_t;

endpackage

// File: rtl/complex_pointwise_divider_core.sv
// ----------------------------------------------------------------------------
// complex_pointwise_divider_core: streaming complex divider
// Divides one complex numerator by one complex denominator per word in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   The source channel (src_valid, src_stall, src_data) takes one word per
//   cycle while src_stall is low, each with a pair index, a numerator and a
//   denominator. The result channel (dst_valid, dst_stall, dst_data) returns
//   one word per input word, in order, with the saturated quotient and its
//   status flags. Words pass through the product and sum stages, 80 divider
//   cells of one quotient bit each, and the output register. Throughput is
//   one word per cycle, set by the chain of divider cells, unless stalled.
//   The whole chain advances together; while a result waits in the output
//   register under dst_stall, src_stall is raised and nothing moves.
//   The cfg channel writes active_pairs; it is always ready. Write it only
//   while no word is in flight.
//   Synchronous reset empties the chain and sets active_pairs to 4096.
// ----------------------------------------------------------------------------
module complex_pointwise_divider_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      src_valid,
  output logic                      src_stall,
  input  cpd_pkg::in_word_t         src_data,
  output logic                      dst_valid,
  input  logic                      dst_stall,
  output cpd_pkg::out_word_t        dst_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cpd_pkg::CFG_W-1:0] cfg_data
);

  logic                        en;
  logic [cpd_pkg::CFG_W-1:0]   active_pairs;
  logic [cpd_pkg::NUM_CELLS:0] chain_valid;
  cpd_pkg::cell_t              chain [cpd_pkg::NUM_CELLS+1];
  cpd_pkg::cell_t              last;
  cpd_pkg::out_word_t          res;
  logic                        sat_re, sat_im;

  assign en = !dst_valid || !dst_stall;
  assign src_stall = !en;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_pairs <= cpd_pkg::CFG_W'(cpd_pkg::MAX_PAIRS);
    end else if (cfg_valid) begin
      active_pairs <= cfg_data;
    end
  end

  cpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .valid_in     (src_valid),
    .word_in      (src_data),
    .active_pairs (active_pairs),
    .valid_out    (chain_valid[0]),
    .cell_out     (chain[0])
  );

  // Chain of division cells, one quotient bit each.
  for (genvar i = 0; i < cpd_pkg::NUM_CELLS; i++) begin : g_cell
    cpd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (chain_valid[i]),
      .cell_in   (chain[i]),
      .valid_out (chain_valid[i+1]),
      .cell_out  (chain[i+1])
    );
  end

  assign last = chain[cpd_pkg::NUM_CELLS];

  // Saturation, sign and status flags of the finished quotient.
  always_comb begin
    sat_re = last.neg_re ?
             (last.big_re || (last.q_re[cpd_pkg::DATA_W-1] &&
                              (last.q_re[cpd_pkg::DATA_W-2:0] != '0))) :
             (last.big_re || last.q_re[cpd_pkg::DATA_W-1]);
    sat_im = last.neg_im ?
             (last.big_im || (last.q_im[cpd_pkg::DATA_W-1] &&
                              (last.q_im[cpd_pkg::DATA_W-2:0] != '0))) :
             (last.big_im || last.q_im[cpd_pkg::DATA_W-1]);
    res = '0;
    if (last.active && last.zero) begin
      res.divide_by_zero = 1'b1;
    end else if (last.active) begin
      res.written = 1'b1;
      res.saturated = sat_re || sat_im;
      if (sat_re) begin
        res.quotient_real = last.neg_re ? {1'b1, {(cpd_pkg::DATA_W-1){1'b0}}} :
                                          {1'b0, {(cpd_pkg::DATA_W-1){1'b1}}};
      end else begin
        res.quotient_real = last.neg_re ? -last.q_re : last.q_re;
      end
      if (sat_im) begin
        res.quotient_imag = last.neg_im ? {1'b1, {(cpd_pkg::DATA_W-1){1'b0}}} :
                                          {1'b0, {(cpd_pkg::DATA_W-1){1'b1}}};
      end else begin
        res.quotient_imag = last.neg_im ? -last.q_im : last.q_im;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (en) begin
      dst_valid <= chain_valid[cpd_pkg::NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst_data <= res;
    end
  end

  // A clipped quotient is always a written one.
  a_sat_written: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.saturated |-> dst_data.written)
    else $error("saturated set on an unwritten word");

  // A word is never both written and a zero divide.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> !(dst_data.written && dst_data.divide_by_zero))
    else $error("written and divide_by_zero both set");

  // An unwritten word carries a zero quotient.
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_data.written |->
      dst_data.quotient_real == '0 && dst_data.quotient_imag == '0)
    else $error("unwritten word with nonzero quotient");

endmodule

// File: rtl/cpd_front.sv
// ----------------------------------------------------------------------------
// cpd_front: products and sums ahead of the divider chain
// Stage one forms the six 32x32 products, stage two the numerator sums in
// sign/magnitude form and the squared magnitude of the denominator.
// ----------------------------------------------------------------------------
module cpd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_in,
  input  cpd_pkg::in_word_t           word_in,
  input  logic [cpd_pkg::CFG_W-1:0]   active_pairs,
  output logic                        valid_out,
  output cpd_pkg::cell_t              cell_out
);

  logic signed [cpd_pkg::PROD_W-1:0] p_rr, p_ii, p_ir, p_ri;
  logic [cpd_pkg::PROD_W-1:0]        d_rr, d_ii;
  logic                              active1;
  logic                              valid1;
  logic [cpd_pkg::CFG_W-1:0]         limit;
  logic signed [cpd_pkg::PROD_W:0]   sum_re, sum_im;
  logic [cpd_pkg::PROD_W-1:0]        den;
  logic [cpd_pkg::PROD_W:0]          mag_re, mag_im;
  cpd_pkg::cell_t                    cell_next;

  // Register beyond the pair count acts as the pair count.
  assign limit = (active_pairs > cpd_pkg::CFG_W'(cpd_pkg::MAX_PAIRS)) ?
                 cpd_pkg::CFG_W'(cpd_pkg::MAX_PAIRS) : active_pairs;

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      valid1 <= valid_in;
      valid_out <= valid1;
    end
  end

  // Stage one: products.
  always_ff @(posedge clk) begin
    if (en) begin
      p_rr <= word_in.numerator_real * word_in.denominator_real;
      p_ii <= word_in.numerator_imag * word_in.denominator_imag;
      p_ir <= word_in.numerator_imag * word_in.denominator_real;
      p_ri <= word_in.numerator_real * word_in.denominator_imag;
      d_rr <= word_in.denominator_real * word_in.denominator_real;
      d_ii <= word_in.denominator_imag * word_in.denominator_imag;
      active1 <= {1'b0, word_in.pair_index} < limit;
    end
  end

  // Stage two: sums, magnitudes and the seed of the division.
  always_comb begin
    sum_re = {p_rr[cpd_pkg::PROD_W-1], p_rr} + {p_ii[cpd_pkg::PROD_W-1], p_ii};
    sum_im = {p_ir[cpd_pkg::PROD_W-1], p_ir} - {p_ri[cpd_pkg::PROD_W-1], p_ri};
    den = d_rr + d_ii;
    mag_re = sum_re[cpd_pkg::PROD_W] ? -sum_re : sum_re;
    mag_im = sum_im[cpd_pkg::PROD_W] ? -sum_im : sum_im;
    cell_next.active = active1;
    cell_next.zero = (den == '0);
    cell_next.den = den;
    cell_next.neg_re = sum_re[cpd_pkg::PROD_W];
    cell_next.neg_im = sum_im[cpd_pkg::PROD_W];
    cell_next.num_re = {mag_re[cpd_pkg::PROD_W-1:0], {cpd_pkg::FRAC_W{1'b0}}};
    cell_next.num_im = {mag_im[cpd_pkg::PROD_W-1:0], {cpd_pkg::FRAC_W{1'b0}}};
    cell_next.rem_re = '0;
    cell_next.rem_im = '0;
    cell_next.q_re = '0;
    cell_next.q_im = '0;
    cell_next.big_re = 1'b0;
    cell_next.big_im = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

// File: rtl/cpd_cell.sv
// ----------------------------------------------------------------------------
// cpd_cell: one restoring division step for both quotient parts
// Shifts in one dividend bit, trial-subtracts the denominator and passes the
// partial remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module cpd_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           valid_in,
  input  cpd_pkg::cell_t cell_in,
  output logic           valid_out,
  output cpd_pkg::cell_t cell_out
);

  logic [cpd_pkg::PROD_W-1:0] t_re, t_im;
  logic                       ge_re, ge_im;
  cpd_pkg::cell_t             cell_next;

  // Trial subtraction on each part; the remainder stays below the denominator.
  always_comb begin
    t_re = {cell_in.rem_re[cpd_pkg::PROD_W-2:0], cell_in.num_re[cpd_pkg::NUM_W-1]};
    t_im = {cell_in.rem_im[cpd_pkg::PROD_W-2:0], cell_in.num_im[cpd_pkg::NUM_W-1]};
    ge_re = (t_re >= cell_in.den);
    ge_im = (t_im >= cell_in.den);
    cell_next = cell_in;
    cell_next.num_re = {cell_in.num_re[cpd_pkg::NUM_W-2:0], 1'b0};
    cell_next.num_im = {cell_in.num_im[cpd_pkg::NUM_W-2:0], 1'b0};
    cell_next.rem_re = ge_re ? (t_re - cell_in.den) : t_re;
    cell_next.rem_im = ge_im ? (t_im - cell_in.den) : t_im;
    cell_next.q_re = {cell_in.q_re[cpd_pkg::DATA_W-2:0], ge_re};
    cell_next.q_im = {cell_in.q_im[cpd_pkg::DATA_W-2:0], ge_im};
    // Any bit shifted out above 32 bits marks an out-of-range quotient.
    cell_next.big_re = cell_in.big_re | cell_in.q_re[cpd_pkg::DATA_W-1];
    cell_next.big_im = cell_in.big_im | cell_in.q_im[cpd_pkg::DATA_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule
